// ===== hdl/mpwsm_pkg.sv =====
// Shared types, constants and character helpers for the multi-pattern word matcher.
`default_nettype none

package mpwsm_pkg;

    localparam int CHAR_W  = 8;
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int INDEX_W = 4;
    localparam int FOUND_W = 4;
    localparam int POS_W   = 16;
    localparam int CFG_W   = 5;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [POS_W-1:0] POS_FIRST = 16'd1;
    localparam logic [POS_W-1:0] POS_MAX   = 16'hFFFF;

    typedef struct packed {
        logic              step;     // text item accepted this cycle
        logic              last;     // that text item ends the word
        logic              restart;  // restart item accepted this cycle
        logic [CHAR_W-1:0] ch;       // case-folded text character
    } text_ctl_t;

    typedef struct packed {
        logic               last;    // character ends the pattern
        logic [INDEX_W-1:0] idx;     // character position within the pattern
        logic [CHAR_W-1:0]  ch;      // raw pattern character
    } load_ctl_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'd65 && c <= 8'd90)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/multi_pattern_word_substring_match.sv =====
// Top level of the case-insensitive multi-pattern word substring matcher.
//
//  Channel   Handshake              Payload
//  cmd       cmd_valid / cmd_stall  operation, pattern_slot, char_index, char_value, last_char
//  res       res_valid / res_stall  matched, pattern_found, word_position
//  cfg       cfg_valid / cfg_ready  cfg_data (patterns in use)
//
// One command item is taken every cycle unless cmd_stall is high; all pattern cells compare
// the character at once. A word-end item's result passes from the cell chain into a capture
// register and then, through the priority encoder, into the output register that drives res.
// cmd_stall is high while a captured word waits for the output register and the result
// held there is stalled by res_stall; the block then holds two results.
// Reset clears pattern lengths, prefix bits and the counter (to one); pattern characters
// hold nothing defined until loaded and need no clearing pass. cfg_ready is always high.
`default_nettype none

module multi_pattern_word_substring_match #(
    parameter int NUM_PATTERNS    = 16,
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_stall,
    input  wire logic [mpwsm_pkg::OP_W-1:0]        operation,
    input  wire logic [mpwsm_pkg::SLOT_W-1:0]      pattern_slot,
    input  wire logic [mpwsm_pkg::INDEX_W-1:0]     char_index,
    input  wire logic [mpwsm_pkg::CHAR_W-1:0]      char_value,
    input  wire logic                              last_char,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic                                   matched,
    output logic [mpwsm_pkg::FOUND_W-1:0]          pattern_found,
    output logic [mpwsm_pkg::POS_W-1:0]            word_position,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpwsm_pkg::CFG_W-1:0]       cfg_data
);
    import mpwsm_pkg::*;

    logic                    cmd_accept;
    logic                    move;
    text_ctl_t               ctl;
    load_ctl_t               ld;
    logic [NUM_PATTERNS-1:0] word_hit;

    logic [CFG_W-1:0]        used_reg;
    logic [POS_W-1:0]        counter_reg;
    logic [POS_W-1:0]        counter_next;
    logic                    pend_reg;
    logic [NUM_PATTERNS-1:0] found_reg;
    logic [POS_W-1:0]        pend_pos_reg;
    logic                    res_valid_reg;
    logic                    matched_reg;
    logic [FOUND_W-1:0]      pattern_found_reg;
    logic [POS_W-1:0]        word_position_reg;

    logic                    enc_hit;
    logic [FOUND_W-1:0]      enc_index;

    assign move       = pend_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall  = pend_reg && !move;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cfg_ready  = 1'b1;

    assign ctl.step    = cmd_accept && (operation == OP_TEXT);
    assign ctl.last    = last_char;
    assign ctl.restart = cmd_accept && (operation == OP_RESTART);
    assign ctl.ch      = fold_char(char_value);

    assign ld.last = last_char;
    assign ld.idx  = char_index;
    assign ld.ch   = char_value;

    genvar p;
    generate
        for (p = 0; p < NUM_PATTERNS; p++)
        begin : g_pattern
            mpwsm_pattern_cell #(
                .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
            ) u_pattern (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .ld       (ld),
                .ld_en    (cmd_accept && (operation == OP_LOAD) &&
                           (32'(pattern_slot) == p)),
                .word_hit (word_hit[p])
            );
        end
    endgenerate

    // Lowest-numbered pattern in use that occurred in the finished word.
    always_comb
    begin
        enc_hit   = 1'b0;
        enc_index = '0;
        for (int i = NUM_PATTERNS - 1; i >= 0; i--)
        begin
            if (found_reg[i] && (32'(used_reg) > i))
            begin
                enc_hit   = 1'b1;
                enc_index = FOUND_W'(i);
            end
        end
    end

    // Punctuation inside a word counts as a word break; the word end itself counts once.
    always_comb
    begin
        counter_next = counter_reg;
        if (ctl.restart)
        begin
            counter_next = POS_FIRST;
        end
        else if (ctl.step && (ctl.last || is_punct(ctl.ch)) && (counter_reg != POS_MAX))
        begin
            counter_next = counter_reg + POS_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            counter_reg   <= POS_FIRST;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            if (cfg_valid && cfg_ready)
            begin
                used_reg <= cfg_data;
            end
            if (ctl.step && ctl.last)
            begin
                pend_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_reg <= 1'b0;
            end
            if (move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.last)
        begin
            found_reg    <= word_hit;
            pend_pos_reg <= counter_reg;
        end
        if (move)
        begin
            matched_reg       <= enc_hit;
            pattern_found_reg <= enc_index;
            word_position_reg <= pend_pos_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign matched       = matched_reg;
    assign pattern_found = pattern_found_reg;
    assign word_position = word_position_reg;

endmodule

`default_nettype wire

// ===== hdl/mpwsm_char_cell.sv =====
// One character position of a pattern: stored character and its prefix match bit.
`default_nettype none

module mpwsm_char_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mpwsm_pkg::text_ctl_t      ctl,
    input  wire logic                      wr_en,
    input  wire logic [mpwsm_pkg::CHAR_W-1:0] wr_char,
    input  wire logic                      active,
    input  wire logic                      prev_bit,
    output logic                           hit,
    output logic                           bit_q
);
    import mpwsm_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic              bit_reg;
    logic              bit_next;

    // The prefix ending one position earlier, at the previous character, extends here.
    assign hit   = prev_bit && active && (char_reg == ctl.ch);
    assign bit_q = bit_reg;

    always_comb
    begin
        bit_next = bit_reg;
        if (ctl.restart || (ctl.step && ctl.last))
        begin
            bit_next = 1'b0;
        end
        else if (ctl.step)
        begin
            bit_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    // Characters are stored already folded to lower case.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= fold_char(wr_char);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mpwsm_pattern_cell.sv =====
// One pattern slot: its length, a chain of character cells and the word-seen flag.
`default_nettype none

module mpwsm_pattern_cell #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mpwsm_pkg::text_ctl_t ctl,
    input  wire mpwsm_pkg::load_ctl_t ld,
    input  wire logic                 ld_en,
    output logic                      word_hit
);
    import mpwsm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

    logic [LEN_W-1:0]           len_reg;
    logic                       seen_reg;
    logic                       seen_next;
    logic [MAX_PATTERN_LEN-1:0] bit_q;
    logic [MAX_PATTERN_LEN-1:0] hit;
    logic [MAX_PATTERN_LEN-1:0] end_hit;
    logic                       idx_ok;

    assign idx_ok = 32'(ld.idx) < MAX_PATTERN_LEN;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_LEN; k++)
        begin : g_char
            logic prev_bit;
            if (k == 0)
            begin : g_head
                assign prev_bit = 1'b1;
            end
            else
            begin : g_link
                assign prev_bit = bit_q[k-1];
            end

            mpwsm_char_cell u_char (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .wr_en    (ld_en && (32'(ld.idx) == k)),
                .wr_char  (ld.ch),
                .active   (32'(len_reg) > k),
                .prev_bit (prev_bit),
                .hit      (hit[k]),
                .bit_q    (bit_q[k])
            );

            assign end_hit[k] = hit[k] && (32'(len_reg) == k + 1);
        end
    endgenerate

    // A whole occurrence ends at the current character when the full-length prefix hits.
    assign word_hit = seen_reg || (ctl.step && (|end_hit));

    always_comb
    begin
        seen_next = seen_reg;
        if (ctl.restart || (ctl.step && ctl.last))
        begin
            seen_next = 1'b0;
        end
        else if (ctl.step)
        begin
            seen_next = word_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (ld_en && ld.last && idx_ok)
            begin
                len_reg <= LEN_W'({1'b0, ld.idx} + 5'd1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== verif/multi_pattern_word_substring_match_tb.sv =====
// Self-checking testbench for the multi-pattern word substring matcher.
`timescale 1ns / 100ps

module multi_pattern_word_substring_match_tb;

    import mpwsm_pkg::*;

    localparam int SLOTS       = 16;
    localparam int PAT_LEN     = 16;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int REPORT_MAX  = 10;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  slot;
        logic [INDEX_W-1:0] idx;
        logic [CHAR_W-1:0]  ch;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [FOUND_W-1:0] found;
        logic [POS_W-1:0]   pos;
    } word_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    logic [OP_W-1:0]      operation = OP_TEXT;
    logic [SLOT_W-1:0]    pattern_slot = '0;
    logic [INDEX_W-1:0]   char_index = '0;
    logic [CHAR_W-1:0]    char_value = '0;
    logic                 last_char = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 matched;
    logic [FOUND_W-1:0]   pattern_found;
    logic [POS_W-1:0]     word_position;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Pending command items and the word results they are due to produce.
    cmd_t      cmd_backlog [$];
    word_res_t word_results_due [$];

    // Matcher state as predicted by the testbench.
    logic [CHAR_W-1:0] pat_mem [SLOTS*PAT_LEN];
    logic [4:0]        pat_len [SLOTS];
    logic [15:0]       prefix_hits [SLOTS];
    logic              seen_in_word [SLOTS];
    logic [POS_W-1:0]  word_pos;
    logic [CFG_W-1:0]  active_patterns;

    // What the stimulus generator knows has been loaded, so that no unwritten
    // pattern character is ever brought into play.
    logic [CHAR_W-1:0] gen_pat [SLOTS][PAT_LEN];
    logic [15:0]       gen_written [SLOTS];
    int                gen_len [SLOTS];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_arm = 1'b0;
    bit  hold_done;
    int  hold_left;
    int  queued_items = 0;
    int  accepted_items = 0;
    int  results_seen = 0;
    int  hit_words = 0;
    int  fail_count = 0;
    word_res_t want_res;

    multi_pattern_word_substring_match dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .operation     (operation),
        .pattern_slot  (pattern_slot),
        .char_index    (char_index),
        .char_value    (char_value),
        .last_char     (last_char),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .matched       (matched),
        .pattern_found (pattern_found),
        .word_position (word_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] lower_case(input logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_mark(input logic [CHAR_W-1:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic [CHAR_W-1:0] mix_case(input logic [CHAR_W-1:0] c);
        if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(1) == 1)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char();
        case ($urandom_range(7))
            0: return "a";
            1: return "b";
            2: return "c";
            3: return "A";
            4: return "B";
            5: return "C";
            6: return "!";
            default: return ".";
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] word_char();
        case ($urandom_range(15))
            0, 1: return "a";
            2:    return "B";
            3:    return "c";
            4:    return "b";
            5:    return "!";
            6:    return ".";
            7:    return " ";
            8:    return "0";
            9:    return "~";
            10:   return "[";
            11:   return "@";
            12:   return "C";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One accepted command item through the predicted matcher.
    task automatic advance_matcher(input cmd_t c);
        logic [CHAR_W-1:0] ch;
        logic [15:0]       eq;
        logic [15:0]       v;
        int                p;
        int                k;
        int                len;
        int                used;
        word_res_t         r;
        case (c.op)
            OP_LOAD:
            begin
                pat_mem[{c.slot, c.idx}] = c.ch;
                if (c.last)
                begin
                    pat_len[c.slot] = {1'b0, c.idx} + 5'd1;
                end
            end
            OP_RESTART:
            begin
                word_pos = POS_FIRST;
                for (p = 0; p < SLOTS; p++)
                begin
                    prefix_hits[p] = '0;
                    seen_in_word[p] = 1'b0;
                end
            end
            OP_TEXT:
            begin
                ch = lower_case(c.ch);
                for (p = 0; p < SLOTS; p++)
                begin
                    len = int'(pat_len[p]);
                    eq = '0;
                    for (k = 0; k < len; k++)
                    begin
                        if (lower_case(pat_mem[p*PAT_LEN + k]) == ch)
                        begin
                            eq[k] = 1'b1;
                        end
                    end
                    v = ((prefix_hits[p] << 1) | 16'd1) & eq;
                    prefix_hits[p] = v;
                    if (len > 0 && v[len-1])
                    begin
                        seen_in_word[p] = 1'b1;
                    end
                end
                if (!c.last)
                begin
                    if (is_mark(ch) && word_pos != POS_MAX)
                    begin
                        word_pos = word_pos + POS_FIRST;
                    end
                end
                else
                begin
                    used = (int'(active_patterns) > SLOTS) ? SLOTS : int'(active_patterns);
                    r.hit = 1'b0;
                    r.found = '0;
                    // Walk downwards so that the lowest matching slot wins.
                    for (p = used - 1; p >= 0; p--)
                    begin
                        if (seen_in_word[p])
                        begin
                            r.hit = 1'b1;
                            r.found = FOUND_W'(p);
                        end
                    end
                    r.pos = word_pos;
                    word_results_due.push_back(r);
                    if (word_pos != POS_MAX)
                    begin
                        word_pos = word_pos + POS_FIRST;
                    end
                    for (p = 0; p < SLOTS; p++)
                    begin
                        prefix_hits[p] = '0;
                        seen_in_word[p] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_item(input cmd_t c);
        cmd_backlog.push_back(c);
        if (c.op != OP_SPARE)
        begin
            queued_items++;
        end
    endtask

    task automatic queue_text(input logic [CHAR_W-1:0] ch, input logic last);
        queue_item({OP_TEXT, 4'($urandom_range(15)), 4'($urandom_range(15)), ch, last});
    endtask

    // A load may only close a pattern once every character below it is written.
    task automatic queue_load(input logic [SLOT_W-1:0] slot, input logic [INDEX_W-1:0] idx,
                              input logic [CHAR_W-1:0] ch, input logic last);
        logic [15:0] need;
        need = 16'((17'd2 << idx) - 17'd1);
        gen_written[slot][idx] = 1'b1;
        gen_pat[slot][idx] = ch;
        if (last && (gen_written[slot] & need) != need)
        begin
            last = 1'b0;
        end
        if (last)
        begin
            gen_len[slot] = int'(idx) + 1;
        end
        queue_item({OP_LOAD, slot, idx, ch, last});
    endtask

    task automatic queue_pattern(input int slot, input int len);
        int k;
        for (k = 0; k < len; k++)
        begin
            queue_load(4'(slot), 4'(k), pattern_char(), k == len - 1);
        end
    endtask

    // A word of filler characters, optionally with a loaded pattern inside it.
    task automatic queue_word(input bit embed);
        logic [CHAR_W-1:0] w [$];
        int n;
        int at;
        int s;
        int k;
        s = $urandom_range(SLOTS - 1);
        if (gen_len[s] == 0)
        begin
            embed = 1'b0;
        end
        n = embed ? $urandom_range(5) : $urandom_range(6, 1);
        at = $urandom_range(n);
        for (k = 0; k <= n; k++)
        begin
            if (embed && k == at)
            begin
                for (int j = 0; j < gen_len[s]; j++)
                begin
                    w.push_back(mix_case(gen_pat[s][j]));
                end
            end
            if (k < n)
            begin
                w.push_back(word_char());
            end
        end
        for (k = 0; k < w.size(); k++)
        begin
            queue_text(w[k], k == w.size() - 1);
        end
    endtask

    task automatic run_random(input int target);
        int goal;
        int r;
        int k;
        int n;
        goal = queued_items + target;
        while (queued_items < goal)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                queue_word(1'($urandom_range(1)));
            end
            else if (r < 68)
            begin
                queue_pattern($urandom_range(SLOTS - 1),
                              ($urandom_range(9) == 0) ? $urandom_range(PAT_LEN, 4)
                                                       : $urandom_range(3, 1));
            end
            else if (r < 78)
            begin
                queue_load(4'($urandom_range(15)), 4'($urandom_range(15)),
                           8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (r < 84)
            begin
                queue_item({OP_RESTART, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            8'($urandom_range(255)), 1'($urandom_range(1))});
            end
            else if (r < 88)
            begin
                queue_item({OP_SPARE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            8'($urandom_range(255)), 1'($urandom_range(1))});
            end
            else
            begin
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++)
                begin
                    queue_text(8'($urandom_range(255)), k == n - 1);
                end
            end
        end
    endtask

    // Samples a little after the edge so that this edge's updates have landed.
    task automatic wait_drained(input int settle);
        do
        begin
            @(posedge clk);
            #1;
        end
        while (cmd_backlog.size() != 0 || cmd_valid || word_results_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_patterns_in_use(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        active_patterns = v;
        cfg_valid <= 1'b0;
    endtask

    // Command driver: a new item is offered only once the last one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            operation <= OP_TEXT;
            pattern_slot <= '0;
            char_index <= '0;
            char_value <= '0;
            last_char <= 1'b0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                {operation, pattern_slot, char_index, char_value, last_char}
                    <= cmd_backlog.pop_front();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            accepted_items++;
            advance_matcher({operation, pattern_slot, char_index, char_value, last_char});
        end
    end

    // Result side: checks each word result and drives the stall, including
    // one long hold-off so that the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (word_results_due.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                    begin
                        $display("unexpected word result: matched=%0d pattern=%0d position=%0d",
                                 matched, pattern_found, word_position);
                    end
                    fail_count++;
                end
                else
                begin
                    want_res = word_results_due.pop_front();
                    results_seen++;
                    if (want_res.hit)
                    begin
                        hit_words++;
                    end
                    if (matched !== want_res.hit || pattern_found !== want_res.found ||
                        word_position !== want_res.pos)
                    begin
                        if (fail_count < REPORT_MAX)
                        begin
                            $display({"word result mismatch: expected matched=%0d pattern=%0d ",
                                      "position=%0d, got matched=%0d pattern=%0d position=%0d"},
                                     want_res.hit, want_res.found, want_res.pos,
                                     matched, pattern_found, word_position);
                        end
                        fail_count++;
                    end
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                res_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        int s;
        for (s = 0; s < SLOTS; s++)
        begin
            pat_len[s] = '0;
            prefix_hits[s] = '0;
            seen_in_word[s] = 1'b0;
            gen_written[s] = '0;
            gen_len[s] = 0;
        end
        word_pos = POS_FIRST;
        active_patterns = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 82;

        // With the register at its reset value nothing may match.
        queue_load(4'd0, 4'd0, "a", 1'b0);
        queue_load(4'd0, 4'd1, "B", 1'b1);
        queue_load(4'd3, 4'd0, "!", 1'b1);
        queue_text("A", 1'b0);
        queue_text("b", 1'b1);
        wait_drained(SETTLE);

        set_patterns_in_use(5'd16);
        queue_text("x", 1'b0);
        queue_text("a", 1'b0);
        queue_text("B", 1'b0);
        queue_text("y", 1'b1);
        // A pattern split across two words must not be found.
        queue_text("a", 1'b1);
        queue_text("b", 1'b1);
        // Punctuation inside a word moves the position on; at the end it does not.
        queue_text("!", 1'b0);
        queue_text(8'hFF, 1'b1);
        queue_text(8'h00, 1'b1);
        // A pattern loaded in the middle of a word counts from the next character.
        queue_text("a", 1'b0);
        queue_load(4'd5, 4'd0, "Z", 1'b1);
        queue_text("z", 1'b1);
        queue_item({OP_SPARE, 4'd15, 4'd15, 8'hFF, 1'b1});
        queue_text("c", 1'b0);
        queue_item({OP_RESTART, 4'd0, 4'd0, 8'h00, 1'b0});
        queue_text("q", 1'b0);
        queue_text(" ", 1'b0);
        queue_text("@", 1'b1);
        wait_drained(SETTLE);

        set_patterns_in_use(5'($urandom_range(15, 1)));
        for (s = 0; s < SLOTS; s++)
        begin
            queue_pattern(s, (s == SLOTS - 1) ? PAT_LEN : $urandom_range(3, 1));
        end
        run_random(130);
        // The sender pauses here until every word result is back.
        wait_drained(SETTLE);
        run_random(130);
        wait_drained(SETTLE);

        send_idle_pct = 82;
        recv_idle_pct = 29;
        set_patterns_in_use(5'd31);
        run_random(260);
        wait_drained(SETTLE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_patterns_in_use(5'd16);
        hold_arm = 1'b1;
        run_random(270);
        wait_drained(SETTLE);

        $display("Run covered %0d command items and %0d word results, %0d of them matches.",
                 accepted_items, results_seen, hit_words);
        $display("Patterns in use 0, 16, 31 and one in between; a long output hold-off.");
        if (fail_count == 0 && word_results_due.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
